// File: rtl/core/pbm_bitmap_stream_decoder_assert.svh
// Assertion macros for the PBM bitmap stream decoder.
// Included by files that check their own logic; depends on nothing else.
`ifndef PBM_BITMAP_STREAM_DECODER_ASSERT_SVH
`define PBM_BITMAP_STREAM_DECODER_ASSERT_SVH
`ifndef ASSERT_OFF
// Property that must hold at every rising clock edge outside reset.
`define PBM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");
// Condition that must never be true outside reset.
`define PBM_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define PBM_ASSERT(lbl, clk, rst_n, prop)
`define PBM_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// File: rtl/core/pbm_pkg.sv
// Shared types and constants of the PBM bitmap stream decoder.
// Used by the front end, the command queue, the back end and the top level.
`timescale 1ns / 1ps

package pbm_pkg;

  // Parser phase of the front end.
  typedef enum logic [2:0] {
    PH_MAGIC,
    PH_WIDTH,
    PH_HEIGHT,
    PH_ASCII,
    PH_BINARY
  } phase_e;

  // Result kind codes as seen on the result port.
  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  // Characters the parser looks for.
  localparam logic [7:0] CHAR_P    = 8'h50;
  localparam logic [7:0] CHAR_ONE  = 8'h31;
  localparam logic [7:0] CHAR_FOUR = 8'h34;
  localparam logic [7:0] CHAR_HASH = 8'h23;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // Pixels carried by one binary byte.
  localparam logic [3:0] PIX_PER_BYTE = 4'd8;

  // One command from the front end to the back end.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  bits;
    logic [15:0] width;
    logic [15:0] height;
    logic [15:0] row;
    logic [15:0] col;
    logic [3:0]  count;
    logic        last;
  } cmd_t;

  // One result beat.
  typedef struct packed {
    kind_e       kind;
    logic [15:0] width;
    logic [15:0] height;
    logic        value;
    logic [15:0] row;
    logic [15:0] col;
    logic        last;
  } result_t;

  // Space, tab, LF, CR, VT and FF.
  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) ||
           (c == 8'h0D) || (c == 8'h0B) || (c == 8'h0C);
  endfunction

endpackage

// File: rtl/core/pbm_front.sv
// Front end: parses the header byte by byte and turns image bytes into commands.
// Depends on pbm_pkg.
`timescale 1ns / 1ps

module pbm_front #(
  parameter int MAX_DIM = 65535
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     data_byte_i,
  output logic           cmd_valid_o,
  output pbm_pkg::cmd_t  cmd_o
);

  pbm_pkg::phase_e phase_q, phase_d;
  logic        in_comment_q, in_comment_d;
  logic        started_q, started_d;
  logic [1:0]  tok_len_q, tok_len_d;
  logic [7:0]  first_q, first_d;
  logic [7:0]  second_q, second_d;
  logic [15:0] acc_q, acc_d;
  logic        digits_open_q, digits_open_d;
  logic        binary_q, binary_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic [15:0] row_q, row_d;
  logic [15:0] col_q, col_d;

  logic [16:0] col_inc;
  logic [16:0] row_inc;
  logic [16:0] remain;
  logic [3:0]  n_bin;
  logic [16:0] col_bin;
  logic [19:0] acc_mult;
  logic [15:0] acc_sat;
  logic        is_digit;
  logic        is_ws;
  logic        wrap;
  logic        done;
  logic        go_start;
  logic        clear_tok;

  // Shared arithmetic for pixel positions and decimal accumulation.
  always_comb begin
    col_inc  = {1'b0, col_q} + 17'd1;
    row_inc  = {1'b0, row_q} + 17'd1;
    remain   = {1'b0, width_q} - {1'b0, col_q};
    n_bin    = (remain >= {13'd0, pbm_pkg::PIX_PER_BYTE}) ? pbm_pkg::PIX_PER_BYTE
                                                         : remain[3:0];
    col_bin  = {1'b0, col_q} + {13'd0, n_bin};
    is_digit = (data_byte_i >= pbm_pkg::CHAR_ZERO) && (data_byte_i <= pbm_pkg::CHAR_NINE);
    is_ws    = pbm_pkg::is_space(data_byte_i);
    acc_mult = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} +
               {16'd0, data_byte_i[3:0] - pbm_pkg::CHAR_ZERO[3:0]};
    acc_sat  = (acc_mult > 20'(MAX_DIM)) ? 16'(MAX_DIM) : acc_mult[15:0];
  end

  // Next state and command for the accepted beat.
  always_comb begin
    phase_d       = phase_q;
    in_comment_d  = in_comment_q;
    started_d     = started_q;
    tok_len_d     = tok_len_q;
    first_d       = first_q;
    second_d      = second_q;
    acc_d         = acc_q;
    digits_open_d = digits_open_q;
    binary_d      = binary_q;
    width_d       = width_q;
    height_d      = height_q;
    row_d         = row_q;
    col_d         = col_q;
    cmd_valid_o   = 1'b0;
    cmd_o         = '0;
    cmd_o.kind    = pbm_pkg::KIND_PIXEL;
    wrap          = 1'b0;
    done          = 1'b0;
    go_start      = 1'b0;
    clear_tok     = 1'b0;

    if (accept_i) begin
      case (phase_q)
        pbm_pkg::PH_ASCII: begin
          if (!is_ws) begin
            wrap = col_inc >= {1'b0, width_q};
            done = wrap && (row_inc >= {1'b0, height_q});
            col_d = wrap ? 16'd0 : col_inc[15:0];
            row_d = wrap ? row_inc[15:0] : row_q;
            cmd_valid_o = 1'b1;
            cmd_o.bits  = {(data_byte_i == pbm_pkg::CHAR_ONE), 7'd0};
            cmd_o.row   = row_q;
            cmd_o.col   = col_q;
            cmd_o.count = 4'd1;
            cmd_o.last  = done;
            go_start    = done;
          end
        end
        pbm_pkg::PH_BINARY: begin
          // A byte never runs past the end of its row.
          wrap = col_bin >= {1'b0, width_q};
          done = wrap && (row_inc >= {1'b0, height_q});
          col_d = wrap ? 16'd0 : col_bin[15:0];
          row_d = wrap ? row_inc[15:0] : row_q;
          cmd_valid_o = 1'b1;
          cmd_o.bits  = data_byte_i;
          cmd_o.row   = row_q;
          cmd_o.col   = col_q;
          cmd_o.count = n_bin;
          cmd_o.last  = done;
          go_start    = done;
        end
        pbm_pkg::PH_MAGIC, pbm_pkg::PH_WIDTH, pbm_pkg::PH_HEIGHT: begin
          if (!started_q) begin
            // Skip whitespace and comments before a token.
            if (in_comment_q) begin
              if (data_byte_i == pbm_pkg::CHAR_LF) begin
                in_comment_d = 1'b0;
              end
            end else if (data_byte_i == pbm_pkg::CHAR_HASH) begin
              in_comment_d = 1'b1;
            end else if (!is_ws) begin
              started_d = 1'b1;
              first_d   = data_byte_i;
              tok_len_d = 2'd1;
              if (is_digit) begin
                acc_d = acc_sat;
              end else begin
                digits_open_d = 1'b0;
              end
            end
          end else if (is_ws) begin
            // The token ends on this byte.
            clear_tok = 1'b1;
            case (phase_q)
              pbm_pkg::PH_MAGIC: begin
                if ((tok_len_q == 2'd2) && (first_q == pbm_pkg::CHAR_P) &&
                    ((second_q == pbm_pkg::CHAR_ONE) ||
                     (second_q == pbm_pkg::CHAR_FOUR))) begin
                  binary_d = (second_q == pbm_pkg::CHAR_FOUR);
                  phase_d  = pbm_pkg::PH_WIDTH;
                end else begin
                  cmd_valid_o = 1'b1;
                  cmd_o.kind  = pbm_pkg::KIND_ERROR;
                  cmd_o.count = 4'd1;
                  go_start    = 1'b1;
                end
              end
              pbm_pkg::PH_WIDTH: begin
                width_d = acc_q;
                phase_d = pbm_pkg::PH_HEIGHT;
              end
              default: begin
                height_d     = acc_q;
                row_d        = 16'd0;
                col_d        = 16'd0;
                cmd_valid_o  = 1'b1;
                cmd_o.kind   = pbm_pkg::KIND_HEADER;
                cmd_o.width  = width_q;
                cmd_o.height = acc_q;
                cmd_o.count  = 4'd1;
                cmd_o.last   = (width_q == 16'd0) || (acc_q == 16'd0);
                go_start     = cmd_o.last;
                phase_d      = binary_q ? pbm_pkg::PH_BINARY : pbm_pkg::PH_ASCII;
              end
            endcase
          end else begin
            // Another byte of the current token.
            if (tok_len_q == 2'd1) begin
              second_d = data_byte_i;
            end
            if (tok_len_q != 2'd3) begin
              tok_len_d = tok_len_q + 2'd1;
            end
            if (digits_open_q) begin
              if (is_digit) begin
                acc_d = acc_sat;
              end else begin
                digits_open_d = 1'b0;
              end
            end
          end
        end
        default: begin
          go_start = 1'b1;
        end
      endcase

      if (clear_tok || go_start) begin
        started_d     = 1'b0;
        tok_len_d     = 2'd0;
        first_d       = 8'd0;
        second_d      = 8'd0;
        acc_d         = 16'd0;
        digits_open_d = 1'b1;
      end
      if (go_start) begin
        in_comment_d = 1'b0;
        phase_d      = pbm_pkg::PH_MAGIC;
        row_d        = 16'd0;
        col_d        = 16'd0;
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= pbm_pkg::PH_MAGIC;
      in_comment_q  <= 1'b0;
      started_q     <= 1'b0;
      tok_len_q     <= 2'd0;
      first_q       <= 8'd0;
      second_q      <= 8'd0;
      acc_q         <= 16'd0;
      digits_open_q <= 1'b1;
      binary_q      <= 1'b0;
      width_q       <= 16'd0;
      height_q      <= 16'd0;
      row_q         <= 16'd0;
      col_q         <= 16'd0;
    end else begin
      phase_q       <= phase_d;
      in_comment_q  <= in_comment_d;
      started_q     <= started_d;
      tok_len_q     <= tok_len_d;
      first_q       <= first_d;
      second_q      <= second_d;
      acc_q         <= acc_d;
      digits_open_q <= digits_open_d;
      binary_q      <= binary_d;
      width_q       <= width_d;
      height_q      <= height_d;
      row_q         <= row_d;
      col_q         <= col_d;
    end
  end

endmodule

// File: rtl/core/pbm_cmd_fifo.sv
// Two-entry command queue between the front end and the back end.
// Depends on pbm_pkg.
`timescale 1ns / 1ps

module pbm_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  pbm_pkg::cmd_t wr_cmd_i,
  input  logic          rd_en_i,
  output logic          valid_o,
  output logic          full_o,
  output pbm_pkg::cmd_t head_o
);

  pbm_pkg::cmd_t entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign head_o  = entry_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_en_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = rd_en_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, wr_en_i} - {1'b0, rd_en_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      entry_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

endmodule

// File: rtl/core/pbm_back.sv
// Back end: expands each command into result beats held in an output register.
// Depends on pbm_pkg.
`timescale 1ns / 1ps

module pbm_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  pbm_pkg::cmd_t    cmd_i,
  output logic             cmd_pop_o,
  input  logic             pop_i,
  output logic             res_valid_o,
  output pbm_pkg::result_t res_o
);

  logic [2:0]       idx_q, idx_d;
  logic             valid_q, valid_d;
  pbm_pkg::result_t res_q, res_d;
  logic             last_beat;
  logic             load;
  logic [7:0]       shifted;

  assign res_valid_o = valid_q;
  assign res_o       = res_q;

  // Build the next beat from the head command and the beat index.
  always_comb begin
    last_beat = (({1'b0, idx_q} + 4'd1) == cmd_i.count);
    load      = cmd_valid_i && (!valid_q || pop_i);
    cmd_pop_o = load && last_beat;
    shifted   = cmd_i.bits << idx_q;

    res_d      = '0;
    res_d.kind = cmd_i.kind;
    case (cmd_i.kind)
      pbm_pkg::KIND_HEADER: begin
        res_d.width  = cmd_i.width;
        res_d.height = cmd_i.height;
        res_d.last   = cmd_i.last;
      end
      pbm_pkg::KIND_PIXEL: begin
        res_d.value = shifted[7];
        res_d.row   = cmd_i.row;
        res_d.col   = cmd_i.col + {13'd0, idx_q};
        res_d.last  = cmd_i.last && last_beat;
      end
      default: begin
      end
    endcase

    if (load) begin
      idx_d   = last_beat ? 3'd0 : idx_q + 3'd1;
      valid_d = 1'b1;
    end else begin
      idx_d   = idx_q;
      valid_d = pop_i ? 1'b0 : valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 3'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

endmodule

// File: rtl/core/pbm_bitmap_stream_decoder.sv
// PBM (P1/P4) bitmap stream decoder. One byte per cycle is accepted in the header
// and in ASCII data while the command queue is not full; the back end expands a
// binary byte into one result beat per pixel it holds (up to 8), and a two-entry
// command queue decouples the two sides. Results are held in an output register.
// Reset (asynchronous, active low) returns the parser to waiting for a magic token.
`timescale 1ns / 1ps
`include "pbm_bitmap_stream_decoder_assert.svh"

module pbm_bitmap_stream_decoder #(
  parameter int MAX_DIM = 65535
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  result_kind_o,
  output logic [15:0] image_width_o,
  output logic [15:0] image_height_o,
  output logic        pixel_value_o,
  output logic [15:0] pixel_row_o,
  output logic [15:0] pixel_col_o,
  output logic        last_of_image_o
);

  logic             accept;
  logic             cmd_push;
  pbm_pkg::cmd_t    cmd_in;
  logic             cmd_valid;
  logic             cmd_full;
  logic             cmd_pop;
  pbm_pkg::cmd_t    cmd_head;
  logic             res_valid;
  pbm_pkg::result_t res;

  // An input beat is taken whenever the command queue has room.
  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  pbm_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .data_byte_i(data_byte_i),
    .cmd_valid_o(cmd_push),
    .cmd_o      (cmd_in)
  );

  pbm_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (cmd_push),
    .wr_cmd_i(cmd_in),
    .rd_en_i (cmd_pop),
    .valid_o (cmd_valid),
    .full_o  (cmd_full),
    .head_o  (cmd_head)
  );

  pbm_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd_head),
    .cmd_pop_o  (cmd_pop),
    .pop_i      (pop && res_valid),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // Result ports.
  assign empty           = !res_valid;
  assign result_kind_o   = res.kind;
  assign image_width_o   = res.width;
  assign image_height_o  = res.height;
  assign pixel_value_o   = res.value;
  assign pixel_row_o     = res.row;
  assign pixel_col_o     = res.col;
  assign last_of_image_o = res.last;

  // The front end never writes a full command queue.
  `PBM_ASSERT_NEVER(a_no_queue_overflow, clk_i, rst_ni, cmd_push && cmd_full)

  // An error result never marks the end of an image.
  `PBM_ASSERT_NEVER(a_error_not_last, clk_i, rst_ni,
    !empty && (res.kind == pbm_pkg::KIND_ERROR) && last_of_image_o)

  // A header of an empty image is the last result of that image.
  `PBM_ASSERT(a_empty_image_last, clk_i, rst_ni,
    (!empty && (res.kind == pbm_pkg::KIND_HEADER) &&
     ((image_width_o == 16'd0) || (image_height_o == 16'd0))) |-> last_of_image_o)

endmodule

// File: test/pbm_bitmap_stream_decoder_test.sv
// Self-checking testbench for the PBM bitmap stream decoder: a directed table, then
// random P1/P4 files with comments, odd tokens and noise, checked by a local decoder.
// Depends on pbm_pkg and the pbm_bitmap_stream_decoder top level.
`timescale 1ns / 1ps

module pbm_bitmap_stream_decoder_test;

  localparam int DIM_LIMIT = 65535;
  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_BYTES = 285;
  localparam int TAIL_BYTES = 50;
  localparam int SETTLE_CYCLES = 16;

  // Whitespace characters of the format.
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_VT = 8'h0B;
  localparam logic [7:0] CHAR_FF = 8'h0C;
  localparam logic [7:0] BLANK_CHARS [6] = '{CHAR_SPACE, CHAR_TAB, pbm_pkg::CHAR_LF,
                                             CHAR_CR, CHAR_VT, CHAR_FF};

  // Directed stimulus: one byte per row, with a typed-in result where it is obvious.
  typedef struct packed {
    logic [7:0]       data;
    logic             typed;
    pbm_pkg::result_t want;
  } stim_row_t;

  localparam pbm_pkg::result_t NO_RESULT = '0;
  localparam pbm_pkg::result_t BAD_MAGIC = '{pbm_pkg::KIND_ERROR, 16'd0, 16'd0, 1'b0,
                                             16'd0, 16'd0, 1'b0};
  localparam pbm_pkg::result_t SATURATED_EMPTY = '{pbm_pkg::KIND_HEADER, 16'hFFFF, 16'd0,
                                                   1'b0, 16'd0, 16'd0, 1'b1};
  localparam pbm_pkg::result_t P4_HEADER = '{pbm_pkg::KIND_HEADER, 16'd3, 16'd2, 1'b0,
                                             16'd0, 16'd0, 1'b0};

  localparam stim_row_t DIRECTED_ROWS [27] = '{
    // "P2#" is one token with a hash inside it, and not a known magic.
    '{pbm_pkg::CHAR_P, 1'b0, NO_RESULT}, '{8'h32, 1'b0, NO_RESULT},
    '{pbm_pkg::CHAR_HASH, 1'b0, NO_RESULT}, '{pbm_pkg::CHAR_LF, 1'b1, BAD_MAGIC},
    // ASCII header with a saturating width and a height with no leading digit.
    '{pbm_pkg::CHAR_P, 1'b0, NO_RESULT}, '{pbm_pkg::CHAR_ONE, 1'b0, NO_RESULT},
    '{CHAR_SPACE, 1'b0, NO_RESULT}, '{pbm_pkg::CHAR_NINE, 1'b0, NO_RESULT},
    '{pbm_pkg::CHAR_NINE, 1'b0, NO_RESULT}, '{pbm_pkg::CHAR_NINE, 1'b0, NO_RESULT},
    '{pbm_pkg::CHAR_NINE, 1'b0, NO_RESULT}, '{pbm_pkg::CHAR_NINE, 1'b0, NO_RESULT},
    '{CHAR_TAB, 1'b0, NO_RESULT}, '{8'h78, 1'b0, NO_RESULT},
    '{pbm_pkg::CHAR_LF, 1'b1, SATURATED_EMPTY},
    // A comment holding an all-ones byte.
    '{pbm_pkg::CHAR_HASH, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT},
    '{pbm_pkg::CHAR_LF, 1'b0, NO_RESULT},
    // Binary 3x2 image: each row starts a new byte and padding bits are dropped.
    '{pbm_pkg::CHAR_P, 1'b0, NO_RESULT}, '{pbm_pkg::CHAR_FOUR, 1'b0, NO_RESULT},
    '{CHAR_CR, 1'b0, NO_RESULT}, '{8'h33, 1'b0, NO_RESULT},
    '{CHAR_VT, 1'b0, NO_RESULT}, '{8'h32, 1'b0, NO_RESULT},
    '{CHAR_FF, 1'b1, P4_HEADER}, '{8'hA5, 1'b0, NO_RESULT},
    '{8'h7F, 1'b0, NO_RESULT}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  data_byte_i;
  logic        empty;
  logic        pop;
  logic [1:0]  result_kind_o;
  logic [15:0] image_width_o;
  logic [15:0] image_height_o;
  logic        pixel_value_o;
  logic [15:0] pixel_row_o;
  logic [15:0] pixel_col_o;
  logic        last_of_image_o;

  pbm_bitmap_stream_decoder uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .data_byte_i    (data_byte_i),
    .empty          (empty),
    .pop            (pop),
    .result_kind_o  (result_kind_o),
    .image_width_o  (image_width_o),
    .image_height_o (image_height_o),
    .pixel_value_o  (pixel_value_o),
    .pixel_row_o    (pixel_row_o),
    .pixel_col_o    (pixel_col_o),
    .last_of_image_o(last_of_image_o)
  );

  // Decoder state kept by the testbench.
  pbm_pkg::phase_e parse_phase;
  logic   skipping_comment;
  logic   token_open;
  int     token_len;
  logic [7:0] tok_char0;
  logic [7:0] tok_char1;
  int     dim_value;
  logic   digits_live;
  logic   p4_mode;
  int     img_width;
  int     img_height;
  int     cur_row;
  int     cur_col;

  pbm_pkg::result_t step_results[$];
  pbm_pkg::result_t pending_results[$];
  logic [7:0]       stream_bytes[$];

  int mismatch_count = 0;
  int result_beats = 0;
  int cycle_count = 0;
  int push_idle_pct = 30;
  int pop_idle_pct = 30;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic is_blank(input logic [7:0] c);
    foreach (BLANK_CHARS[i]) begin
      if (c == BLANK_CHARS[i]) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic pbm_pkg::result_t make_result(input pbm_pkg::kind_e k, input int w,
                                                   input int h, input logic v,
                                                   input int row, input int col,
                                                   input logic last);
    pbm_pkg::result_t r;
    r.kind = k;
    r.width = w[15:0];
    r.height = h[15:0];
    r.value = v;
    r.row = row[15:0];
    r.col = col[15:0];
    r.last = last;
    return r;
  endfunction

  function void clear_token();
    token_open = 1'b0;
    token_len = 0;
    tok_char0 = '0;
    tok_char1 = '0;
    dim_value = 0;
    digits_live = 1'b1;
  endfunction

  // Back to waiting for a magic token.
  function void restart();
    clear_token();
    skipping_comment = 1'b0;
    parse_phase = pbm_pkg::PH_MAGIC;
    cur_row = 0;
    cur_col = 0;
  endfunction

  // Steps the raster position; returns 1 once the last pixel has gone.
  function automatic logic next_position();
    cur_col++;
    if (cur_col >= img_width) begin
      cur_col = 0;
      cur_row++;
      if (cur_row >= img_height) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Works out the results that one input byte causes, into step_results.
  task automatic decode_byte(input logic [7:0] c);
    int   row_was;
    int   col_was;
    int   bitpos;
    logic done;
    step_results.delete();
    if (parse_phase == pbm_pkg::PH_ASCII) begin
      if (!is_blank(c)) begin
        row_was = cur_row;
        col_was = cur_col;
        done = next_position();
        step_results.push_back(make_result(pbm_pkg::KIND_PIXEL, 0, 0,
                                           c == pbm_pkg::CHAR_ONE, row_was,
                                           col_was, done));
        if (done) restart();
      end
      return;
    end
    if (parse_phase == pbm_pkg::PH_BINARY) begin
      // MSB first; a row change ends the byte.
      for (bitpos = 7; bitpos >= 0; bitpos--) begin
        row_was = cur_row;
        col_was = cur_col;
        done = next_position();
        step_results.push_back(make_result(pbm_pkg::KIND_PIXEL, 0, 0, c[bitpos],
                                           row_was, col_was, done));
        if (done) begin
          restart();
          break;
        end
        if (cur_row != row_was) break;
      end
      return;
    end

    // Header: skip whitespace and comments, then collect a token.
    if (!token_open) begin
      if (skipping_comment) begin
        if (c == pbm_pkg::CHAR_LF) skipping_comment = 1'b0;
        return;
      end
      if (c == pbm_pkg::CHAR_HASH) begin
        skipping_comment = 1'b1;
        return;
      end
      if (is_blank(c)) return;
      token_open = 1'b1;
    end else if (is_blank(c)) begin
      case (parse_phase)
        pbm_pkg::PH_MAGIC: begin
          if (token_len == 2 && tok_char0 == pbm_pkg::CHAR_P &&
              (tok_char1 == pbm_pkg::CHAR_ONE || tok_char1 == pbm_pkg::CHAR_FOUR)) begin
            p4_mode = (tok_char1 == pbm_pkg::CHAR_FOUR);
            clear_token();
            parse_phase = pbm_pkg::PH_WIDTH;
          end else begin
            step_results.push_back(make_result(pbm_pkg::KIND_ERROR, 0, 0, 1'b0, 0, 0,
                                               1'b0));
            restart();
          end
        end
        pbm_pkg::PH_WIDTH: begin
          img_width = dim_value;
          clear_token();
          parse_phase = pbm_pkg::PH_HEIGHT;
        end
        default: begin
          // This byte is the separator before the image data.
          img_height = dim_value;
          clear_token();
          cur_row = 0;
          cur_col = 0;
          if (img_width == 0 || img_height == 0) begin
            step_results.push_back(make_result(pbm_pkg::KIND_HEADER, img_width,
                                               img_height, 1'b0, 0, 0, 1'b1));
            restart();
          end else begin
            step_results.push_back(make_result(pbm_pkg::KIND_HEADER, img_width,
                                               img_height, 1'b0, 0, 0, 1'b0));
            parse_phase = p4_mode ? pbm_pkg::PH_BINARY : pbm_pkg::PH_ASCII;
          end
        end
      endcase
      return;
    end

    // The byte belongs to the current token.
    if (token_len == 0) tok_char0 = c;
    else if (token_len == 1) tok_char1 = c;
    if (token_len < 3) token_len++;
    if (digits_live) begin
      if (c >= pbm_pkg::CHAR_ZERO && c <= pbm_pkg::CHAR_NINE) begin
        dim_value = dim_value * 10 + int'(c - pbm_pkg::CHAR_ZERO);
        if (dim_value > DIM_LIMIT) dim_value = DIM_LIMIT;
      end else begin
        digits_live = 1'b0;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input longint got,
                                 input longint wanted);
    $display("beat %0d: %s is %0d, predicted %0d", result_beats, what, got, wanted);
    mismatch_count++;
  endtask

  // Random file generation.
  function automatic logic [7:0] pick_char(input logic no_digits, input logic no_hash);
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (is_blank(b) ||
               (no_digits && b >= pbm_pkg::CHAR_ZERO && b <= pbm_pkg::CHAR_NINE) ||
               (no_hash && b == pbm_pkg::CHAR_HASH));
    return b;
  endfunction

  function void add_blank();
    stream_bytes.push_back(BLANK_CHARS[$urandom_range(0, 5)]);
  endfunction

  function void add_comment();
    logic [7:0] b;
    int n;
    n = $urandom_range(0, 5);
    stream_bytes.push_back(pbm_pkg::CHAR_HASH);
    repeat (n) begin
      do b = 8'($urandom_range(0, 255)); while (b == pbm_pkg::CHAR_LF);
      stream_bytes.push_back(b);
    end
    stream_bytes.push_back(pbm_pkg::CHAR_LF);
  endfunction

  function void add_gap();
    add_blank();
    if ($urandom_range(0, 5) == 0) add_comment();
    if ($urandom_range(0, 5) == 0) add_blank();
  endfunction

  // A number token whose leading digits give the value, sometimes dressed up.
  function void add_number(input int value);
    string digits;
    digits = $sformatf("%0d", value);
    if (value == 0 && $urandom_range(0, 2) == 0) begin
      stream_bytes.push_back(pick_char(1'b1, 1'b1));
      if ($urandom_range(0, 1) == 0) stream_bytes.push_back(8'($urandom_range(8'h30, 8'h39)));
      return;
    end
    if ($urandom_range(0, 4) == 0) stream_bytes.push_back(pbm_pkg::CHAR_ZERO);
    for (int i = 0; i < digits.len(); i++) stream_bytes.push_back(digits[i]);
    if ($urandom_range(0, 6) == 0) begin
      stream_bytes.push_back(pick_char(1'b1, 1'b0));
      if ($urandom_range(0, 1) == 0) stream_bytes.push_back(pick_char(1'b0, 1'b0));
    end
  endfunction

  function void add_image();
    logic binary;
    int   w;
    int   h;
    int   big;
    int   n;
    // Occasional line of noise ahead of the file.
    if ($urandom_range(0, 19) == 0) begin
      n = $urandom_range(1, 4);
      repeat (n) stream_bytes.push_back(8'($urandom_range(0, 255)));
      stream_bytes.push_back(pbm_pkg::CHAR_LF);
    end
    if ($urandom_range(0, 3) == 0) add_comment();
    if ($urandom_range(0, 3) == 0) add_blank();
    // Broken magic tokens.
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0: stream_bytes.push_back(pbm_pkg::CHAR_P);
        1: begin
          stream_bytes.push_back(pbm_pkg::CHAR_P);
          stream_bytes.push_back(pick_char(1'b0, 1'b0));
        end
        2: begin
          stream_bytes.push_back(pbm_pkg::CHAR_P);
          stream_bytes.push_back(pbm_pkg::CHAR_ONE);
          stream_bytes.push_back(pbm_pkg::CHAR_FOUR);
        end
        default: begin
          stream_bytes.push_back(pick_char(1'b0, 1'b1));
          stream_bytes.push_back(pick_char(1'b0, 1'b0));
        end
      endcase
      add_blank();
      return;
    end
    binary = 1'($urandom_range(0, 1));
    stream_bytes.push_back(pbm_pkg::CHAR_P);
    stream_bytes.push_back(binary ? pbm_pkg::CHAR_FOUR : pbm_pkg::CHAR_ONE);
    add_gap();
    // Mostly small images; large sizes only where the other side is zero.
    if ($urandom_range(0, 99) < 80) begin
      w = (binary && $urandom_range(0, 2) == 0) ? $urandom_range(1, 20)
                                                 : $urandom_range(1, 6);
      h = $urandom_range(1, 4);
    end else begin
      case ($urandom_range(0, 4))
        0: big = 65535;
        1: big = 65536;
        2: big = 99999;
        3: big = $urandom_range(0, 9);
        default: big = $urandom_range(0, 70000);
      endcase
      if ($urandom_range(0, 1) == 0) begin
        w = big;
        h = 0;
      end else begin
        w = 0;
        h = big;
      end
    end
    add_number(w);
    add_gap();
    add_number(h);
    add_blank();
    if (w == 0 || h == 0) return;
    if (binary) begin
      repeat (h * ((w + 7) / 8)) stream_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat (w * h) begin
        if ($urandom_range(0, 4) == 0) add_blank();
        n = $urandom_range(0, 99);
        if (n < 45) stream_bytes.push_back(pbm_pkg::CHAR_ONE);
        else if (n < 80) stream_bytes.push_back(pbm_pkg::CHAR_ZERO);
        else stream_bytes.push_back(pick_char(1'b0, 1'b0));
      end
    end
  endfunction

  // Offers one byte, waits for it to be taken, and queues what it should cause.
  task automatic send_byte(input logic [7:0] b, input logic typed,
                           input pbm_pkg::result_t typed_res);
    if ($urandom_range(0, 99) < push_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    push <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (full);
    decode_byte(b);
    if (typed) begin
      pending_results.push_back(typed_res);
    end else begin
      foreach (step_results[i]) pending_results.push_back(step_results[i]);
    end
  endtask

  // Stimulus, end of run and final verdict.
  initial begin : stimulus
    int sent;
    rst_ni <= 1'b0;
    push <= 1'b0;
    data_byte_i <= '0;
    restart();
    p4_mode = 1'b0;
    img_width = 0;
    img_height = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED_ROWS[k]) begin
      send_byte(DIRECTED_ROWS[k].data, DIRECTED_ROWS[k].typed, DIRECTED_ROWS[k].want);
    end

    while (stream_bytes.size() < RANDOM_BYTES) add_image();
    sent = 0;
    while (stream_bytes.size() > 0) begin
      // Idle rates change in stretches and drop to zero near the end.
      if (stream_bytes.size() <= TAIL_BYTES) begin
        push_idle_pct = 0;
        pop_idle_pct = 0;
      end else if (sent % 32 == 0) begin
        push_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 60);
        pop_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 60);
      end
      send_byte(stream_bytes.pop_front(), 1'b0, NO_RESULT);
      sent++;
    end
    push <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      report_mismatch("results never delivered", pending_results.size(), 0);
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Result side: pop held high with random stall bursts.
  initial begin : result_drain
    pop <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if ($urandom_range(0, 99) < pop_idle_pct) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Compare each accepted result beat with the oldest prediction.
  always @(posedge clk_i) begin
    pbm_pkg::result_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result kind", result_kind_o, -1);
      end else begin
        want = pending_results.pop_front();
        if (result_kind_o !== want.kind)
          report_mismatch("result_kind", result_kind_o, want.kind);
        if (image_width_o !== want.width)
          report_mismatch("image_width", image_width_o, want.width);
        if (image_height_o !== want.height)
          report_mismatch("image_height", image_height_o, want.height);
        if (pixel_value_o !== want.value)
          report_mismatch("pixel_value", pixel_value_o, want.value);
        if (pixel_row_o !== want.row)
          report_mismatch("pixel_row", pixel_row_o, want.row);
        if (pixel_col_o !== want.col)
          report_mismatch("pixel_col", pixel_col_o, want.col);
        if (last_of_image_o !== want.last)
          report_mismatch("last_of_image", last_of_image_o, want.last);
      end
      result_beats++;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
